FILE: rtl/igf_pkg.sv
// Shared constants, types and kernel weight tables for the iterated Gaussian frame filter.
package igf_pkg;

  localparam int ADDR_W = 16;
  localparam int POS_W  = ADDR_W + 1;
  localparam int PIX_W  = 24;
  localparam int FRAC_W = 16;
  localparam int RAW_W  = 8;
  localparam int ACC_W  = 32;
  localparam int PROD_W = 30;
  localparam int DIM_W  = 9;
  localparam int PASS_W = 4;
  localparam int WT_W   = 6;
  localparam int TAP_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int DEPTH  = 1 << ADDR_W;

  localparam logic [DIM_W-1:0] MAX_DIM = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT  = 2'd3;

  typedef logic [WT_W-1:0] wt_t;

  localparam wt_t W3 [9] = '{6'd1, 6'd2, 6'd1,
                             6'd2, 6'd4, 6'd2,
                             6'd1, 6'd2, 6'd1};

  localparam wt_t W5 [25] = '{6'd1, 6'd4,  6'd6,  6'd4,  6'd1,
                              6'd4, 6'd16, 6'd24, 6'd16, 6'd4,
                              6'd6, 6'd24, 6'd36, 6'd24, 6'd6,
                              6'd4, 6'd16, 6'd24, 6'd16, 6'd4,
                              6'd1, 6'd4,  6'd6,  6'd4,  6'd1};

  // Product of the row and column binomial taps for tap number t in raster order.
  function automatic wt_t tap_weight(input logic big, input logic [TAP_W-1:0] t);
    wt_t w;
    w = '0;
    if (big) begin
      if (t < 5'd25) w = W5[t];
    end else begin
      if (t < 5'd9) w = W3[t[3:0]];
    end
    return w;
  endfunction

  typedef struct packed {
    logic              rd_en;
    logic              src_b;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
  } pass_req_t;

endpackage

FILE: rtl/igf_if.sv
// Valid/ready channel interfaces for input pixels and result pixels.
interface igf_in_if (input logic clk);
  logic                        valid;
  logic                        ready;
  logic [igf_pkg::RAW_W-1:0]   pixel_in;
  logic                        frame_end;
  modport source (output valid, output pixel_in, output frame_end, input ready);
  modport sink (input valid, input pixel_in, input frame_end, output ready);
endinterface

interface igf_out_if (input logic clk);
  logic                        valid;
  logic                        ready;
  logic [igf_pkg::PIX_W-1:0]   pixel_out;
  logic                        out_valid;
  logic                        out_last;
  modport source (output valid, output pixel_out, output out_valid, output out_last,
                  input ready);
  modport sink (input valid, input pixel_out, input out_valid, input out_last,
                output ready);
endinterface

FILE: rtl/igf_ram.sv
// Generic single-port RAM with registered read.
module igf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end

endmodule

FILE: rtl/igf_pass.sv
// Pass sequencer: one buffer read and one multiply-accumulate per cycle in P_TAP.
module igf_pass (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         kmode,
  input  logic [igf_pkg::DIM_W-1:0]    fw,
  input  logic [igf_pkg::DIM_W-1:0]    fh,
  input  logic [igf_pkg::PASS_W-1:0]   npass,
  input  logic [igf_pkg::PIX_W-1:0]    src_rdata,
  output igf_pkg::pass_req_t           req,
  output logic                         done,
  output logic                         res_in_b
);

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_SETUP = 2'd1;
  localparam logic [1:0] P_TAP   = 2'd2;
  localparam logic [1:0] P_LAST  = 2'd3;

  logic [1:0]                    state;
  logic                          big;
  logic [igf_pkg::DIM_W-1:0]     w;
  logic [igf_pkg::DIM_W-1:0]     h;
  logic [igf_pkg::PASS_W-1:0]    npass_q;
  logic [igf_pkg::PASS_W-1:0]    pcnt;
  logic                          in_b;
  logic [igf_pkg::DIM_W-1:0]     i;
  logic [igf_pkg::DIM_W-1:0]     j;
  logic [igf_pkg::ADDR_W-1:0]    base;
  logic [igf_pkg::ADDR_W-1:0]    off;
  logic [igf_pkg::ADDR_W-1:0]    taddr;
  logic [igf_pkg::TAP_W-1:0]     t;
  logic [2:0]                    dx;
  logic                          vd;
  igf_pkg::wt_t                  wt_d;
  logic [igf_pkg::ACC_W-1:0]     acc;

  logic [igf_pkg::DIM_W-1:0]     r;
  logic [igf_pkg::DIM_W-1:0]     r2;
  logic [2:0]                    dmax;
  logic [igf_pkg::TAP_W-1:0]     tlast;
  logic [igf_pkg::PROD_W-1:0]    prod;
  logic [igf_pkg::ACC_W-1:0]     sum;
  logic                          last_pass;
  logic [igf_pkg::DIM_W-1:0]     fw_eff;
  logic [igf_pkg::DIM_W-1:0]     fh_eff;
  logic                          no_grid;
  logic                          pass_end;

  assign r     = big ? 9'd2 : 9'd1;
  assign r2    = big ? 9'd4 : 9'd2;
  assign dmax  = big ? 3'd4 : 3'd2;
  assign tlast = big ? 5'd24 : 5'd8;
  assign prod  = src_rdata * wt_d;
  assign sum   = acc + (vd ? igf_pkg::ACC_W'(prod) : '0);
  assign last_pass = (pcnt + 4'd1) == npass_q;
  assign fw_eff = (fw > igf_pkg::MAX_DIM) ? igf_pkg::MAX_DIM : fw;
  assign fh_eff = (fh > igf_pkg::MAX_DIM) ? igf_pkg::MAX_DIM : fh;
  assign no_grid  = (w <= r2) || (h <= r2);
  assign pass_end = ((state == P_SETUP) && no_grid) ||
                    ((state == P_LAST) && (j == w - r - 9'd1) && (i == h - r - 9'd1));

  always_comb begin
    req         = '0;
    req.src_b   = in_b;
    req.rd_addr = taddr;
    req.wr_addr = base + off;
    req.wr_data = big ? sum[31:8] : sum[27:4];
    req.rd_en   = (state == P_TAP);
    req.wr_en   = (state == P_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= P_IDLE;
      done     <= 1'b0;
      res_in_b <= 1'b0;
      in_b     <= 1'b0;
      pcnt     <= '0;
      vd       <= 1'b0;
    end else begin
      done <= ((state == P_IDLE) && start && (npass == '0)) || (pass_end && last_pass);
      case (state)
        P_IDLE: begin
          if (start) begin
            big     <= kmode;
            w       <= fw_eff;
            h       <= fh_eff;
            npass_q <= npass;
            pcnt    <= '0;
            in_b    <= 1'b0;
            if (npass == '0) begin
              res_in_b <= 1'b0;
            end else begin
              state <= P_SETUP;
            end
          end
        end
        P_SETUP: begin
          // A grid with no interior still counts as a pass and swaps the buffers.
          if (no_grid) begin
            pcnt <= pcnt + 4'd1;
            in_b <= ~in_b;
            if (last_pass) begin
              res_in_b <= ~in_b;
              state    <= P_IDLE;
            end
          end else begin
            i     <= r;
            j     <= r;
            base  <= '0;
            taddr <= '0;
            t     <= '0;
            dx    <= '0;
            acc   <= '0;
            vd    <= 1'b0;
            off   <= big ? igf_pkg::ADDR_W'({w, 1'b0}) + 16'd2 : igf_pkg::ADDR_W'(w) + 16'd1;
            state <= P_TAP;
          end
        end
        P_TAP: begin
          acc  <= sum;
          vd   <= 1'b1;
          wt_d <= igf_pkg::tap_weight(big, t);
          if (t == tlast) begin
            state <= P_LAST;
          end else begin
            t <= t + 5'd1;
            if (dx == dmax) begin
              dx    <= '0;
              taddr <= taddr + igf_pkg::ADDR_W'(w) - igf_pkg::ADDR_W'(r2);
            end else begin
              dx    <= dx + 3'd1;
              taddr <= taddr + 16'd1;
            end
          end
        end
        P_LAST: begin
          acc <= '0;
          vd  <= 1'b0;
          t   <= '0;
          dx  <= '0;
          if (j == w - r - 9'd1) begin
            if (i == h - r - 9'd1) begin
              pcnt <= pcnt + 4'd1;
              in_b <= ~in_b;
              if (last_pass) begin
                res_in_b <= ~in_b;
                state    <= P_IDLE;
              end else begin
                state <= P_SETUP;
              end
            end else begin
              // Skip the right border of this line and the left border of the next.
              i     <= i + 9'd1;
              j     <= r;
              base  <= base + igf_pkg::ADDR_W'(r2) + 16'd1;
              taddr <= base + igf_pkg::ADDR_W'(r2) + 16'd1;
              state <= P_TAP;
            end
          end else begin
            j     <= j + 9'd1;
            base  <= base + 16'd1;
            taddr <= base + 16'd1;
            state <= P_TAP;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/iterated_gaussian_frame_filter.sv
// Top level of the iterated Gaussian frame filter: load, result read-out and buffers.
//
// Input items carry one 8-bit pixel in raster order, frame_end on the last one.
// Each accepted item yields one output item: the filtered pixel at the same
// raster position of the previous frame in 8.16 fixed point, out_valid low
// until a first frame has been filtered, out_last on the final position.
// A load item is accepted, then takes a buffer read, then a buffer write that also
// fills the output register. The output register frees the input side; an
// item waits in its write cycle only while a result is still untaken.
// After the item marked frame_end, the filter runs pass_count passes with one
// shared multiply-accumulate unit reading one buffer word a cycle while it
// steps through a pixel's taps: each interior pixel takes one read per tap
// (9 for 3x3, 25 for 5x5) and then a result write; the input is not
// ready meanwhile.
// After reset the second buffer is cleared one word a cycle, all 65536 words,
// before the first item is accepted. Configuration writes are taken at any
// time and are sampled at each frame end.
module iterated_gaussian_frame_filter (
  input  logic                             clk,
  input  logic                             rst,
  igf_in_if.sink                           in_ch,
  igf_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [igf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [igf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_PASS = 3'd4;

  logic [2:0]                      state;
  logic [igf_pkg::ADDR_W-1:0]      clr_addr;
  logic [igf_pkg::POS_W-1:0]       pos;
  logic [igf_pkg::POS_W-1:0]       rlen;
  logic                            res_ready;
  logic                            res_in_b;
  logic [igf_pkg::RAW_W-1:0]       pix;
  logic                            last;

  logic                            kmode;
  logic [igf_pkg::DIM_W-1:0]       fw;
  logic [igf_pkg::DIM_W-1:0]       fh;
  logic [igf_pkg::PASS_W-1:0]      npass;

  logic                            o_valid;
  logic [igf_pkg::PIX_W-1:0]       o_pix;
  logic                            o_ok;
  logic                            o_last;

  logic                            start;
  igf_pkg::pass_req_t              req;
  logic                            pass_done;
  logic                            pass_in_b;

  logic                            a_we, a_re, b_we, b_re;
  logic [igf_pkg::ADDR_W-1:0]      a_addr, b_addr;
  logic [igf_pkg::PIX_W-1:0]       a_wdata, b_wdata, a_rdata, b_rdata;
  logic [igf_pkg::PIX_W-1:0]       src_rdata;
  logic                            in_range;
  logic                            slot_free;
  logic [igf_pkg::POS_W-1:0]       pos_inc;

  assign in_ch.ready      = (state == S_IDLE);
  assign out_ch.valid     = o_valid;
  assign out_ch.pixel_out = o_pix;
  assign out_ch.out_valid = o_ok;
  assign out_ch.out_last  = o_last;

  assign in_range  = ~pos[igf_pkg::POS_W-1];
  assign slot_free = ~o_valid | out_ch.ready;
  assign pos_inc   = pos + (in_range ? 17'd1 : 17'd0);
  assign start     = (state == S_WR) && slot_free && last;
  assign src_rdata = req.src_b ? b_rdata : a_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmode <= 1'b0;
      fw    <= 9'd256;
      fh    <= 9'd256;
      npass <= 4'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        igf_pkg::REG_KERNEL_MODE: kmode <= cfg_data[0];
        igf_pkg::REG_WIDTH:       fw    <= cfg_data;
        igf_pkg::REG_HEIGHT:      fh    <= cfg_data;
        igf_pkg::REG_PASS_COUNT:  npass <= cfg_data[igf_pkg::PASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Buffer port selection; during a pass the source is read and the other buffer written.
  always_comb begin
    a_we    = 1'b0;
    a_re    = 1'b0;
    b_we    = 1'b0;
    b_re    = 1'b0;
    a_addr  = pos[igf_pkg::ADDR_W-1:0];
    b_addr  = pos[igf_pkg::ADDR_W-1:0];
    a_wdata = {pix, {igf_pkg::FRAC_W{1'b0}}};
    b_wdata = '0;
    case (state)
      S_CLR: begin
        b_we   = 1'b1;
        b_addr = clr_addr;
      end
      S_RD: begin
        a_re = in_range;
        b_re = in_range;
      end
      S_WR: begin
        a_we = slot_free && in_range;
        b_we = slot_free && in_range;
      end
      S_PASS: begin
        a_re    = req.rd_en && !req.src_b;
        b_re    = req.rd_en && req.src_b;
        a_we    = req.wr_en && req.src_b;
        b_we    = req.wr_en && !req.src_b;
        a_addr  = req.src_b ? req.wr_addr : req.rd_addr;
        b_addr  = req.src_b ? req.rd_addr : req.wr_addr;
        a_wdata = req.wr_data;
        b_wdata = req.wr_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      pos       <= '0;
      rlen      <= '0;
      res_ready <= 1'b0;
      res_in_b  <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      if ((state == S_WR) && slot_free) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 16'd1;
          if (clr_addr == igf_pkg::ADDR_W'(igf_pkg::DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            pix   <= in_ch.pixel_in;
            last  <= in_ch.frame_end;
            state <= S_RD;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (slot_free) begin
            o_ok    <= res_ready;
            o_pix   <= (res_ready && in_range) ? (res_in_b ? b_rdata : a_rdata) : '0;
            o_last  <= res_ready && (rlen != '0) && (pos == rlen - 17'd1);
            if (last) begin
              rlen  <= pos_inc;
              pos   <= '0;
              state <= S_PASS;
            end else begin
              pos   <= pos_inc;
              state <= S_IDLE;
            end
          end
        end
        S_PASS: begin
          if (pass_done) begin
            res_in_b  <= pass_in_b;
            res_ready <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  igf_pass u_pass (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kmode    (kmode),
    .fw       (fw),
    .fh       (fh),
    .npass    (npass),
    .src_rdata(src_rdata),
    .req      (req),
    .done     (pass_done),
    .res_in_b (pass_in_b)
  );

  igf_ram #(.WIDTH(igf_pkg::PIX_W), .DEPTH(igf_pkg::DEPTH)) u_buf_a (
    .clk  (clk),
    .we   (a_we),
    .re   (a_re),
    .addr (a_addr),
    .wdata(a_wdata),
    .rdata(a_rdata)
  );

  igf_ram #(.WIDTH(igf_pkg::PIX_W), .DEPTH(igf_pkg::DEPTH)) u_buf_b (
    .clk  (clk),
    .we   (b_we),
    .re   (b_re),
    .addr (b_addr),
    .wdata(b_wdata),
    .rdata(b_rdata)
  );

endmodule
